@@ src/i2c_master_register_access_macros.svh @@
// Assertion macros shared by the I2C master register access RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`endif

@@ src/i2cm_pkg.sv @@
// Shared types and constants of the I2C master register access block.
// Used by the front stage, the command queue, the sequencer and the top level.
package i2cm_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCNT_W  = QAW + 1;

    localparam logic [7:0] MSB_MASK      = 8'h80;
    localparam logic [7:0] READ_BIT      = 8'h01;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [1:0] PHASE_ADDR = 2'd0;
    localparam logic [1:0] PHASE_REG  = 2'd1;
    localparam logic [1:0] PHASE_DATA = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_S_SDA1 = 5'd1,
        ST_S_SCL1 = 5'd2,
        ST_S_SDA0 = 5'd3,
        ST_S_SCL0 = 5'd4,
        ST_T_SDA  = 5'd5,
        ST_T_SCL1 = 5'd6,
        ST_T_SCL0 = 5'd7,
        ST_A_SDA1 = 5'd8,
        ST_A_SCL1 = 5'd9,
        ST_A_SCL0 = 5'd10,
        ST_P_SDA0 = 5'd11,
        ST_P_SCL1 = 5'd12,
        ST_P_SDA1 = 5'd13,
        ST_R_SDA1 = 5'd14,
        ST_R_SCL1 = 5'd15,
        ST_R_SCL0 = 5'd16,
        ST_K_SDA  = 5'd17,
        ST_K_SCL1 = 5'd18,
        ST_K_SCL0 = 5'd19
    } step_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       request_rejected;
        logic       done_res;
        logic       status;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
    } res_t;

endpackage

@@ src/i2c_master_register_access.sv @@
// Top level of the I2C master register access block.
// Instantiates i2cm_front, i2cm_queue and i2cm_seq; depends on i2cm_pkg.
//
// Usage: every item on the slave stream is a tick (tuser 0) or a register
// write (1) or read (2) request; tuser 3 is ignored. A request only latches
// its operands; each following tick performs one SCL or SDA change of the
// bus sequence. Every item gives exactly one result on the master stream
// with both pin drive levels, busy, request-rejected, done and status flags
// and, on the tick that completes a received byte, that byte (tuser set,
// tlast on the last byte of the read).
// Path: an accepted item passes the input register, the queue and the
// sequencer output register on its way to the result; the input register
// loads at the accepting edge.
// Throughput: one item per cycle unless the result is held; the sequencer retires
// one queued item per clock, and its single state update per item sets that figure.
// Reset: the bus is released (SCL and SDA high), the sequencer is idle and
// the queue is empty.
// Stall: while the result is not taken, the sequencer holds; the four-entry
// queue and the input stage keep accepting items until they are full.
module i2c_master_register_access (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: device_addr[7:0], reg_addr[15:8], write_data[23:16],
    //        read_count[31:24], sda_in[32], zero fill[39:33]
    input  logic [i2cm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [i2cm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: scl_out[0], sda_out[1], busy_res[2], request_rejected[3],
    //        done_res[4], status[5], rx_byte[13:6], zero fill[15:14]
    output logic [i2cm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: rx_valid[0]
    output logic [0:0]                      m_axis_tuser,
    // tlast: rx_last
    output logic                            m_axis_tlast
);

    logic           front_push;
    logic           q_in_ready;
    i2cm_pkg::cmd_t front_cmd;
    logic           q_out_valid;
    logic           seq_ready;
    i2cm_pkg::cmd_t q_cmd;
    i2cm_pkg::res_t res;

    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser),
        .push       (front_push),
        .push_ready (q_in_ready),
        .cmd        (front_cmd)
    );

    i2cm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_push),
        .in_ready  (q_in_ready),
        .in_cmd    (front_cmd),
        .out_valid (q_out_valid),
        .out_ready (seq_ready),
        .out_cmd   (q_cmd)
    );

    i2cm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_out_valid),
        .cmd_ready (seq_ready),
        .cmd       (q_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {2'b00, res.rx_byte, res.status, res.done_res,
                           res.request_rejected, res.busy_res, res.sda_out, res.scl_out};
    assign m_axis_tuser = res.rx_valid;
    assign m_axis_tlast = res.rx_last;

endmodule

@@ src/i2cm_front.sv @@
// Input stage: accepts stream items, decodes the mode into a command kind
// and holds one decoded command for the queue. Depends on i2cm_pkg.
module i2cm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [i2cm_pkg::IN_USER_W-1:0] s_tuser,
    output logic                           push,
    input  logic                           push_ready,
    output i2cm_pkg::cmd_t                 cmd
);

    logic           valid_reg;
    logic           valid_next;
    i2cm_pkg::cmd_t cmd_reg;
    i2cm_pkg::cmd_t cmd_next;
    i2cm_pkg::cmd_t decoded;
    logic           accept;

    always_comb
    begin
        // Every mode value has a kind of its own; the unused code becomes a no-op.
        decoded.kind        = i2cm_pkg::kind_t'(s_tuser);
        decoded.device_addr = s_tdata[7:0];
        decoded.reg_addr    = s_tdata[15:8];
        decoded.write_data  = s_tdata[23:16];
        decoded.read_count  = s_tdata[31:24];
        decoded.sda_in      = s_tdata[32];
    end

    assign s_tready = !valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;
    assign push     = valid_reg;
    assign cmd      = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            cmd_next   = decoded;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

@@ src/i2cm_queue.sv @@
// Short command queue between the input stage and the sequencer.
// Depends on i2cm_pkg for the command type and depth.
module i2cm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  i2cm_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output i2cm_pkg::cmd_t out_cmd
);

    i2cm_pkg::cmd_t                mem [i2cm_pkg::QDEPTH];
    logic [i2cm_pkg::QAW-1:0]      wr_ptr_reg;
    logic [i2cm_pkg::QAW-1:0]      wr_ptr_next;
    logic [i2cm_pkg::QAW-1:0]      rd_ptr_reg;
    logic [i2cm_pkg::QAW-1:0]      rd_ptr_next;
    logic [i2cm_pkg::QCNT_W-1:0]   count_reg;
    logic [i2cm_pkg::QCNT_W-1:0]   count_next;
    logic                          wr_en;
    logic                          rd_en;

    assign in_ready  = count_reg != i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_en ? i2cm_pkg::QAW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? i2cm_pkg::QAW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = i2cm_pkg::QCNT_W'(count_reg + 1'b1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = i2cm_pkg::QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ src/i2cm_seq.sv @@
// Bus sequencer: executes one queued command per cycle unless the result is
// held, steps the I2C pin sequence, registers the result. Depends on i2cm_pkg.
`include "i2c_master_register_access_macros.svh"

module i2cm_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  i2cm_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output i2cm_pkg::res_t res
);

    i2cm_pkg::step_t step_reg, step_next;
    logic [3:0]      bit_index_reg, bit_index_next;
    logic [7:0]      shift_reg, shift_next;
    logic [7:0]      bytes_left_reg, bytes_left_next;
    logic [7:0]      dev_reg, dev_next;
    logic [7:0]      regn_reg, regn_next;
    logic [7:0]      data_reg, data_next;
    logic            is_read_reg, is_read_next;
    logic            scl_reg, scl_next;
    logic            sda_reg, sda_next;
    logic [1:0]      phase_reg, phase_next;
    logic            nack_reg, nack_next;
    logic            out_valid_reg, out_valid_next;
    i2cm_pkg::res_t  out_reg;
    i2cm_pkg::res_t  res_next;
    logic            pop;
    logic [3:0]      bit_inc;
    logic [7:0]      rx_shift;
    logic [7:0]      bytes_dec;

    assign cmd_ready = !out_valid_reg || res_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign bit_inc   = 4'(bit_index_reg + 1'b1);
    assign rx_shift  = {shift_reg[6:0], cmd.sda_in};
    assign bytes_dec = (bytes_left_reg != 8'd0) ? 8'(bytes_left_reg - 1'b1) : bytes_left_reg;

    always_comb
    begin
        step_next       = step_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        dev_next        = dev_reg;
        regn_next       = regn_reg;
        data_next       = data_reg;
        is_read_next    = is_read_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        phase_next      = phase_reg;
        nack_next       = nack_reg;
        res_next        = '0;

        case (cmd.kind)
            i2cm_pkg::KIND_WRITE, i2cm_pkg::KIND_READ:
            begin
                if (step_reg != i2cm_pkg::ST_IDLE)
                begin
                    res_next.request_rejected = 1'b1;
                end
                else
                begin
                    dev_next        = cmd.device_addr;
                    regn_next       = cmd.reg_addr;
                    data_next       = cmd.write_data;
                    bytes_left_next = cmd.read_count;
                    is_read_next    = cmd.kind == i2cm_pkg::KIND_READ;
                    phase_next      = i2cm_pkg::PHASE_ADDR;
                    nack_next       = 1'b0;
                    bit_index_next  = 4'd0;
                    shift_next      = 8'd0;
                    step_next       = i2cm_pkg::ST_S_SDA1;
                end
            end
            i2cm_pkg::KIND_TICK:
            begin
                case (step_reg)
                    i2cm_pkg::ST_IDLE:
                    begin
                    end
                    i2cm_pkg::ST_S_SDA1:
                    begin
                        sda_next  = 1'b1;
                        step_next = i2cm_pkg::ST_S_SCL1;
                    end
                    i2cm_pkg::ST_S_SCL1:
                    begin
                        scl_next  = 1'b1;
                        step_next = i2cm_pkg::ST_S_SDA0;
                    end
                    i2cm_pkg::ST_S_SDA0:
                    begin
                        sda_next  = 1'b0;
                        step_next = i2cm_pkg::ST_S_SCL0;
                    end
                    i2cm_pkg::ST_S_SCL0:
                    begin
                        scl_next       = 1'b0;
                        shift_next     = (phase_reg == i2cm_pkg::PHASE_ADDR) ? dev_reg
                                         : (dev_reg | i2cm_pkg::READ_BIT);
                        bit_index_next = 4'd0;
                        step_next      = i2cm_pkg::ST_T_SDA;
                    end
                    i2cm_pkg::ST_T_SDA:
                    begin
                        sda_next  = (shift_reg & i2cm_pkg::MSB_MASK) != 8'd0;
                        step_next = i2cm_pkg::ST_T_SCL1;
                    end
                    i2cm_pkg::ST_T_SCL1:
                    begin
                        scl_next  = 1'b1;
                        step_next = i2cm_pkg::ST_T_SCL0;
                    end
                    i2cm_pkg::ST_T_SCL0:
                    begin
                        scl_next       = 1'b0;
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_index_next = bit_inc;
                        step_next      = (bit_inc >= i2cm_pkg::BITS_PER_BYTE)
                                         ? i2cm_pkg::ST_A_SDA1 : i2cm_pkg::ST_T_SDA;
                    end
                    i2cm_pkg::ST_A_SDA1:
                    begin
                        sda_next  = 1'b1;
                        step_next = i2cm_pkg::ST_A_SCL1;
                    end
                    i2cm_pkg::ST_A_SCL1:
                    begin
                        scl_next  = 1'b1;
                        step_next = i2cm_pkg::ST_A_SCL0;
                    end
                    i2cm_pkg::ST_A_SCL0:
                    begin
                        scl_next = 1'b0;
                        if (cmd.sda_in)
                        begin
                            nack_next = 1'b1;
                            step_next = i2cm_pkg::ST_P_SDA0;
                        end
                        else if (phase_reg == i2cm_pkg::PHASE_ADDR)
                        begin
                            phase_next     = i2cm_pkg::PHASE_REG;
                            shift_next     = regn_reg;
                            bit_index_next = 4'd0;
                            step_next      = i2cm_pkg::ST_T_SDA;
                        end
                        else if (phase_reg == i2cm_pkg::PHASE_REG)
                        begin
                            phase_next = i2cm_pkg::PHASE_DATA;
                            if (is_read_reg)
                            begin
                                // Repeated START before the read address byte.
                                step_next = i2cm_pkg::ST_S_SDA1;
                            end
                            else
                            begin
                                shift_next     = data_reg;
                                bit_index_next = 4'd0;
                                step_next      = i2cm_pkg::ST_T_SDA;
                            end
                        end
                        else if (is_read_reg)
                        begin
                            step_next = (bytes_left_reg == 8'd0)
                                        ? i2cm_pkg::ST_K_SDA : i2cm_pkg::ST_R_SDA1;
                        end
                        else
                        begin
                            step_next = i2cm_pkg::ST_P_SDA0;
                        end
                    end
                    i2cm_pkg::ST_P_SDA0:
                    begin
                        sda_next  = 1'b0;
                        step_next = i2cm_pkg::ST_P_SCL1;
                    end
                    i2cm_pkg::ST_P_SCL1:
                    begin
                        scl_next  = 1'b1;
                        step_next = i2cm_pkg::ST_P_SDA1;
                    end
                    i2cm_pkg::ST_P_SDA1:
                    begin
                        sda_next        = 1'b1;
                        step_next       = i2cm_pkg::ST_IDLE;
                        res_next.done_res = 1'b1;
                        res_next.status   = nack_reg;
                    end
                    i2cm_pkg::ST_R_SDA1:
                    begin
                        sda_next       = 1'b1;
                        bit_index_next = 4'd0;
                        shift_next     = 8'd0;
                        step_next      = i2cm_pkg::ST_R_SCL1;
                    end
                    i2cm_pkg::ST_R_SCL1:
                    begin
                        scl_next  = 1'b1;
                        step_next = i2cm_pkg::ST_R_SCL0;
                    end
                    i2cm_pkg::ST_R_SCL0:
                    begin
                        scl_next       = 1'b0;
                        shift_next     = rx_shift;
                        bit_index_next = bit_inc;
                        if (bit_inc >= i2cm_pkg::BITS_PER_BYTE)
                        begin
                            bytes_left_next   = bytes_dec;
                            res_next.rx_valid = 1'b1;
                            res_next.rx_byte  = rx_shift;
                            res_next.rx_last  = bytes_dec == 8'd0;
                            step_next         = i2cm_pkg::ST_K_SDA;
                        end
                        else
                        begin
                            step_next = i2cm_pkg::ST_R_SCL1;
                        end
                    end
                    i2cm_pkg::ST_K_SDA:
                    begin
                        // ACK while bytes remain, NACK after the last one.
                        sda_next  = bytes_left_reg == 8'd0;
                        step_next = i2cm_pkg::ST_K_SCL1;
                    end
                    i2cm_pkg::ST_K_SCL1:
                    begin
                        scl_next  = 1'b1;
                        step_next = i2cm_pkg::ST_K_SCL0;
                    end
                    i2cm_pkg::ST_K_SCL0:
                    begin
                        scl_next  = 1'b0;
                        step_next = (bytes_left_reg == 8'd0)
                                    ? i2cm_pkg::ST_P_SDA0 : i2cm_pkg::ST_R_SDA1;
                    end
                    default:
                    begin
                        step_next = i2cm_pkg::ST_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        res_next.scl_out  = scl_next;
        res_next.sda_out  = sda_next;
        res_next.busy_res = step_next != i2cm_pkg::ST_IDLE;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= i2cm_pkg::ST_IDLE;
            bit_index_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            bytes_left_reg <= 8'd0;
            dev_reg        <= 8'd0;
            regn_reg       <= 8'd0;
            data_reg       <= 8'd0;
            is_read_reg    <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            phase_reg      <= i2cm_pkg::PHASE_ADDR;
            nack_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                step_reg       <= step_next;
                bit_index_reg  <= bit_index_next;
                shift_reg      <= shift_next;
                bytes_left_reg <= bytes_left_next;
                dev_reg        <= dev_next;
                regn_reg       <= regn_next;
                data_reg       <= data_next;
                is_read_reg    <= is_read_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                phase_reg      <= phase_next;
                nack_reg       <= nack_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res_next;
        end
    end

    `I2CM_ASSERT_NEXT(a_done_goes_idle, pop && res_next.done_res, step_reg == i2cm_pkg::ST_IDLE)
    `I2CM_ASSERT_NOW(a_reject_only_busy, pop && res_next.request_rejected, step_reg != i2cm_pkg::ST_IDLE)
    `I2CM_ASSERT_NOW(a_rx_only_in_read, pop && res_next.rx_valid, is_read_reg && phase_reg == i2cm_pkg::PHASE_DATA)
    `I2CM_ASSERT_NEXT(a_stop_leaves_released, pop && res_next.done_res, scl_reg && sda_reg)

endmodule
